FILE: design/mhp_pkg.sv
// ----------------------------------------------------------------------------
// Message header parser package
// Shared types and codes for the streaming message header parser.
// ----------------------------------------------------------------------------
package mhp_pkg;

    // Parse phase, one-hot coded.
    typedef enum logic [14:0] {
        PH_MF       = 15'b000000000000001,
        PH_SESSION  = 15'b000000000000010,
        PH_SECF     = 15'b000000000000100,
        PH_COUNTER  = 15'b000000000001000,
        PH_SRC      = 15'b000000000010000,
        PH_DSTNODE  = 15'b000000000100000,
        PH_DSTGROUP = 15'b000000001000000,
        PH_XFLAGS   = 15'b000000010000000,
        PH_OPCODE   = 15'b000000100000000,
        PH_EXCH     = 15'b000001000000000,
        PH_PROTO    = 15'b000010000000000,
        PH_VENDOR   = 15'b000100000000000,
        PH_ACK      = 15'b001000000000000,
        PH_PAYLOAD  = 15'b010000000000000,
        PH_DISCARD  = 15'b100000000000000
    } t_phase;

    // Field kinds carried on each result beat.
    localparam logic [3:0] KIND_MSGFLAGS = 4'd0;
    localparam logic [3:0] KIND_SESSION  = 4'd1;
    localparam logic [3:0] KIND_SECFLAGS = 4'd2;
    localparam logic [3:0] KIND_COUNTER  = 4'd3;
    localparam logic [3:0] KIND_SRC      = 4'd4;
    localparam logic [3:0] KIND_DSTNODE  = 4'd5;
    localparam logic [3:0] KIND_DSTGROUP = 4'd6;
    localparam logic [3:0] KIND_XFLAGS   = 4'd7;
    localparam logic [3:0] KIND_OPCODE   = 4'd8;
    localparam logic [3:0] KIND_EXCH     = 4'd9;
    localparam logic [3:0] KIND_PROTO    = 4'd10;
    localparam logic [3:0] KIND_VENDOR   = 4'd11;
    localparam logic [3:0] KIND_ACKCTR   = 4'd12;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd13;
    localparam logic [3:0] KIND_STATUS   = 4'd14;

    // Frame status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_DEST_RSVD = 3'd2;
    localparam logic [2:0] ST_MSG_EXT   = 3'd3;
    localparam logic [2:0] ST_SEC_EXT   = 3'd4;

    // Flag bit masks.
    localparam logic [7:0] MF_SRC_MASK    = 8'h04;
    localparam logic [7:0] MF_DEST_BITS   = 8'h03;
    localparam logic [7:0] SF_MSGEXT_MASK = 8'h20;
    localparam logic [7:0] XF_VENDOR_MASK = 8'h10;
    localparam logic [7:0] XF_ACK_MASK    = 8'h02;
    localparam logic [7:0] XF_SECEXT_MASK = 8'h08;

    // Destination size codes.
    localparam logic [1:0] DSIZ_NODE  = 2'd1;
    localparam logic [1:0] DSIZ_GROUP = 2'd2;
    localparam logic [1:0] DSIZ_RSVD  = 2'd3;

    // One result beat.
    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [2:0]  code;
        logic        last;
    } t_result;

    // Results caused by one input beat: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_emit;

endpackage

FILE: design/mhp_core.sv
// ----------------------------------------------------------------------------
// Message header parser core
// Holds the parse state and turns each accepted byte into its result beats.
// ----------------------------------------------------------------------------
module mhp_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_end,
    output mhp_pkg::t_emit       o_emit
);

    mhp_pkg::t_phase        r_phase, n_phase;
    logic [2:0]             r_idx, n_idx;
    logic [63:0]            r_acc, n_acc;
    logic                   r_src, n_src;
    logic [1:0]             r_dsiz, n_dsiz;
    logic                   r_ack, n_ack;
    logic                   r_vendor, n_vendor;
    logic [2:0]             r_pend, n_pend;
    logic [COUNT_BITS-1:0]  r_count, n_count;

    logic [3:0]             coll_len;
    logic [63:0]            collected;
    logic                   coll_done;
    logic                   fld_vld;
    mhp_pkg::t_result       fld;
    mhp_pkg::t_result       stat;
    mhp_pkg::t_phase        dest_next;
    mhp_pkg::t_phase        msg_end_next;
    mhp_pkg::t_phase        proto_end_next;
    mhp_pkg::t_phase        after_vendor_next;

    // Length in bytes of the multi-byte field being collected.
    always_comb begin
        case (r_phase)
            mhp_pkg::PH_SESSION:  coll_len = 4'd2;
            mhp_pkg::PH_COUNTER:  coll_len = 4'd4;
            mhp_pkg::PH_SRC:      coll_len = 4'd8;
            mhp_pkg::PH_DSTNODE:  coll_len = 4'd8;
            mhp_pkg::PH_DSTGROUP: coll_len = 4'd2;
            mhp_pkg::PH_EXCH:     coll_len = 4'd2;
            mhp_pkg::PH_PROTO:    coll_len = 4'd2;
            mhp_pkg::PH_VENDOR:   coll_len = 4'd2;
            mhp_pkg::PH_ACK:      coll_len = 4'd4;
            default:              coll_len = 4'd1;
        endcase
    end

    // Little-endian assembly of the current field.
    assign collected = r_acc | ({56'd0, i_data_byte} << {r_idx, 3'b000});
    assign coll_done = ({1'b0, r_idx} + 4'd1) >= coll_len;

    // Phase chosen at the ends of the header sections.
    assign msg_end_next   = (r_pend != 3'd0) ? mhp_pkg::PH_DISCARD : mhp_pkg::PH_XFLAGS;
    assign proto_end_next = (r_pend != 3'd0) ? mhp_pkg::PH_DISCARD : mhp_pkg::PH_PAYLOAD;
    assign after_vendor_next = r_ack ? mhp_pkg::PH_ACK : proto_end_next;

    always_comb begin
        if (r_dsiz == mhp_pkg::DSIZ_NODE) begin
            dest_next = mhp_pkg::PH_DSTNODE;
        end else if (r_dsiz == mhp_pkg::DSIZ_GROUP) begin
            dest_next = mhp_pkg::PH_DSTGROUP;
        end else begin
            dest_next = msg_end_next;
        end
    end

    // Saturating count of bytes in the frame, this byte included.
    assign n_count = (r_count != {COUNT_BITS{1'b1}}) ? r_count + 1'b1 : r_count;

    // Parse step for one byte.
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_src    = r_src;
        n_dsiz   = r_dsiz;
        n_ack    = r_ack;
        n_vendor = r_vendor;
        n_pend   = r_pend;
        fld_vld  = 1'b0;
        fld.kind  = mhp_pkg::KIND_PAYLOAD;
        fld.value = {56'd0, i_data_byte};
        fld.code  = mhp_pkg::ST_OK;
        fld.last  = 1'b0;

        case (r_phase)
            mhp_pkg::PH_MF: begin
                fld_vld  = 1'b1;
                fld.kind = mhp_pkg::KIND_MSGFLAGS;
                n_src    = (i_data_byte & mhp_pkg::MF_SRC_MASK) != 8'd0;
                n_dsiz   = i_data_byte[1:0] & mhp_pkg::MF_DEST_BITS[1:0];
                if (n_dsiz == mhp_pkg::DSIZ_RSVD) begin
                    n_pend  = mhp_pkg::ST_DEST_RSVD;
                    n_phase = mhp_pkg::PH_DISCARD;
                end else begin
                    n_phase = mhp_pkg::PH_SESSION;
                end
            end
            mhp_pkg::PH_SECF: begin
                fld_vld  = 1'b1;
                fld.kind = mhp_pkg::KIND_SECFLAGS;
                if ((i_data_byte & mhp_pkg::SF_MSGEXT_MASK) != 8'd0) begin
                    n_pend = mhp_pkg::ST_MSG_EXT;
                end
                n_phase = mhp_pkg::PH_COUNTER;
            end
            mhp_pkg::PH_XFLAGS: begin
                fld_vld  = 1'b1;
                fld.kind = mhp_pkg::KIND_XFLAGS;
                n_vendor = (i_data_byte & mhp_pkg::XF_VENDOR_MASK) != 8'd0;
                n_ack    = (i_data_byte & mhp_pkg::XF_ACK_MASK) != 8'd0;
                if ((i_data_byte & mhp_pkg::XF_SECEXT_MASK) != 8'd0) begin
                    n_pend = mhp_pkg::ST_SEC_EXT;
                end
                n_phase = mhp_pkg::PH_OPCODE;
            end
            mhp_pkg::PH_OPCODE: begin
                fld_vld  = 1'b1;
                fld.kind = mhp_pkg::KIND_OPCODE;
                n_phase  = mhp_pkg::PH_EXCH;
            end
            mhp_pkg::PH_PAYLOAD: begin
                fld_vld  = 1'b1;
                fld.kind = mhp_pkg::KIND_PAYLOAD;
            end
            mhp_pkg::PH_SESSION, mhp_pkg::PH_COUNTER, mhp_pkg::PH_SRC,
            mhp_pkg::PH_DSTNODE, mhp_pkg::PH_DSTGROUP, mhp_pkg::PH_EXCH,
            mhp_pkg::PH_PROTO, mhp_pkg::PH_VENDOR, mhp_pkg::PH_ACK: begin
                fld.value = collected;
                if (coll_done) begin
                    fld_vld = 1'b1;
                    n_acc   = 64'd0;
                    n_idx   = 3'd0;
                    case (r_phase)
                        mhp_pkg::PH_SESSION: begin
                            fld.kind = mhp_pkg::KIND_SESSION;
                            n_phase  = mhp_pkg::PH_SECF;
                        end
                        mhp_pkg::PH_COUNTER: begin
                            fld.kind = mhp_pkg::KIND_COUNTER;
                            n_phase  = r_src ? mhp_pkg::PH_SRC : dest_next;
                        end
                        mhp_pkg::PH_SRC: begin
                            fld.kind = mhp_pkg::KIND_SRC;
                            n_phase  = dest_next;
                        end
                        mhp_pkg::PH_DSTNODE: begin
                            fld.kind = mhp_pkg::KIND_DSTNODE;
                            n_phase  = msg_end_next;
                        end
                        mhp_pkg::PH_DSTGROUP: begin
                            fld.kind = mhp_pkg::KIND_DSTGROUP;
                            n_phase  = msg_end_next;
                        end
                        mhp_pkg::PH_EXCH: begin
                            fld.kind = mhp_pkg::KIND_EXCH;
                            n_phase  = mhp_pkg::PH_PROTO;
                        end
                        mhp_pkg::PH_PROTO: begin
                            fld.kind = mhp_pkg::KIND_PROTO;
                            n_phase  = r_vendor ? mhp_pkg::PH_VENDOR : after_vendor_next;
                        end
                        mhp_pkg::PH_VENDOR: begin
                            fld.kind = mhp_pkg::KIND_VENDOR;
                            n_phase  = after_vendor_next;
                        end
                        default: begin
                            fld.kind = mhp_pkg::KIND_ACKCTR;
                            n_phase  = proto_end_next;
                        end
                    endcase
                end else begin
                    n_acc = collected;
                    n_idx = r_idx + 3'd1;
                end
            end
            default: begin
                // Discard, and any code with no meaning, swallows the byte.
                fld_vld = 1'b0;
            end
        endcase
    end

    // Status beat closing the frame.
    always_comb begin
        stat.kind  = mhp_pkg::KIND_STATUS;
        stat.value = {{(64-COUNT_BITS){1'b0}}, n_count};
        stat.last  = 1'b1;
        if (n_phase == mhp_pkg::PH_PAYLOAD) begin
            stat.code = mhp_pkg::ST_OK;
        end else if (n_pend != 3'd0) begin
            stat.code = n_pend;
        end else begin
            stat.code = mhp_pkg::ST_TRUNCATED;
        end
    end

    // Pack the field beat first, then the status beat.
    always_comb begin
        if (fld_vld) begin
            o_emit.first  = fld;
            o_emit.second = stat;
            o_emit.count  = i_frame_end ? 2'd2 : 2'd1;
        end else begin
            o_emit.first  = stat;
            o_emit.second = stat;
            o_emit.count  = i_frame_end ? 2'd1 : 2'd0;
        end
    end

    // State registers; the frame end returns everything to its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_frame_end)) begin
            r_phase  <= mhp_pkg::PH_MF;
            r_idx    <= 3'd0;
            r_acc    <= 64'd0;
            r_src    <= 1'b0;
            r_dsiz   <= 2'd0;
            r_ack    <= 1'b0;
            r_vendor <= 1'b0;
            r_pend   <= 3'd0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_acc    <= n_acc;
            r_src    <= n_src;
            r_dsiz   <= n_dsiz;
            r_ack    <= n_ack;
            r_vendor <= n_vendor;
            r_pend   <= n_pend;
            r_count  <= n_count;
        end
    end

endmodule

FILE: design/matter_header_parser_top.sv
// ----------------------------------------------------------------------------
// Matter message header parser, top level
// A result beat is registered in the queue before it is offered.
// Throughput: one byte per cycle while ready is high; a frame-end byte that also
// completes a field yields two beats, drained one per cycle while the receiver is
// ready, from a four-beat queue. Ready drops only while the queue cannot take two more beats.
// Reset (synchronous, active low) empties the queue and returns the parser
// to the start of a frame.
// ----------------------------------------------------------------------------
module matter_header_parser_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_field_kind,
    output logic [63:0] o_field_value,
    output logic [2:0]  o_status_code,
    output logic        o_last
);

    mhp_pkg::t_emit   emit;
    mhp_pkg::t_result r_queue [4];
    logic [1:0]       r_wr_ptr, n_wr_ptr;
    logic [1:0]       r_rd_ptr, n_rd_ptr;
    logic [2:0]       r_fill, n_fill;
    logic [1:0]       push_cnt;
    logic             accept;
    logic             pop;
    mhp_pkg::t_result head;

    assign o_ready = r_fill <= 3'd2;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_fill != 3'd0;
    assign pop     = o_valid && i_ready;

    mhp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .o_emit      (emit)
    );

    // Queue pointer and fill arithmetic.
    assign push_cnt = accept ? emit.count : 2'd0;
    assign n_wr_ptr = r_wr_ptr + push_cnt;
    assign n_rd_ptr = r_rd_ptr + {1'b0, pop};
    assign n_fill   = r_fill + {1'b0, push_cnt} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_fill   <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Result storage; up to two beats written per cycle.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= emit.first;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= emit.second;
        end
    end

    // Head of the queue drives the output beat.
    assign head          = r_queue[r_rd_ptr];
    assign o_field_kind  = head.kind;
    assign o_field_value = head.value;
    assign o_status_code = head.code;
    assign o_last        = head.last;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Message header parser testbench
// Drives frames of bytes into the parser, one beat per byte, and checks every
// result beat against a byte-level model of the header walk held here. A short
// table of directed frames comes first. Random frames follow over four idling
// phases: mostly well-formed headers, plus truncated frames and noise.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_BITS   = 16;
    localparam int RAND_ITEMS = 1330;
    localparam int HOLD_LEN   = 300;

    // One row of the directed table. Where typed is set, beat replaces the
    // last beat that the model predicts for this byte.
    typedef struct {
        logic [7:0]       data;
        logic             fend;
        bit               typed;
        mhp_pkg::t_result beat;
    } t_row;

    localparam mhp_pkg::t_result NO_BEAT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_frame_end;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_field_kind;
    logic [63:0] o_field_value;
    logic [2:0]  o_status_code;
    logic        o_last;

    // Expected result beats, oldest first.
    mhp_pkg::t_result field_beats [$];
    int          fail_count = 0;
    int          send_pct   = 0;
    int          recv_pct   = 0;
    bit          hold_armed = 1'b0;
    int          hold_left  = 0;
    int          rand_items = 0;

    // Header walk state.
    mhp_pkg::t_phase       pp_phase;
    int unsigned           pp_idx;
    logic [63:0]           pp_acc;
    logic                  pp_src;
    logic [1:0]            pp_dsiz;
    logic                  pp_ack;
    logic                  pp_vendor;
    logic [2:0]            pp_err;
    logic [CNT_BITS-1:0]   pp_count;

    t_row dir_rows [21] = '{
        // Single-byte frames: reserved destination size twice, then truncation.
        '{8'h03, 1'b1, 1'b1, '{mhp_pkg::KIND_STATUS, 64'd1, mhp_pkg::ST_DEST_RSVD, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, '{mhp_pkg::KIND_STATUS, 64'd1, mhp_pkg::ST_DEST_RSVD, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{mhp_pkg::KIND_STATUS, 64'd1, mhp_pkg::ST_TRUNCATED, 1'b1}},
        // Shortest full header, ending on the last protocol id byte.
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, '{mhp_pkg::KIND_SESSION, 64'hFFFF, mhp_pkg::ST_OK, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, '{mhp_pkg::KIND_COUNTER, 64'hFFFF_FFFF, mhp_pkg::ST_OK, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b1, '{mhp_pkg::KIND_OPCODE, 64'hFF, mhp_pkg::ST_OK, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, 1'b1, '{mhp_pkg::KIND_STATUS, 64'd14, mhp_pkg::ST_OK, 1'b1}},
        // Message extension flag, frame cut after the security flags.
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'h34, 1'b0, 1'b0, NO_BEAT},
        '{8'h12, 1'b0, 1'b0, NO_BEAT},
        '{8'h20, 1'b1, 1'b1, '{mhp_pkg::KIND_STATUS, 64'd4, mhp_pkg::ST_MSG_EXT, 1'b1}}
    };

    matter_header_parser_top #(
        .COUNT_BITS(CNT_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_field_kind (o_field_kind),
        .o_field_value(o_field_value),
        .o_status_code(o_status_code),
        .o_last       (o_last)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Returns the walk to the start of a frame.
    function automatic void clear_walk();
        pp_phase  = mhp_pkg::PH_MF;
        pp_idx    = 0;
        pp_acc    = '0;
        pp_src    = 1'b0;
        pp_dsiz   = '0;
        pp_ack    = 1'b0;
        pp_vendor = 1'b0;
        pp_err    = mhp_pkg::ST_OK;
        pp_count  = '0;
    endfunction

    function automatic void add_beat(input logic [3:0] kind, input logic [63:0] value,
                                     input logic [2:0] code, input logic last);
        mhp_pkg::t_result r;
        r.kind  = kind;
        r.value = value;
        r.code  = code;
        r.last  = last;
        field_beats.push_back(r);
    endfunction

    // Collects one byte of a little-endian field of len bytes; returns 1 once
    // the field is complete, with its value in v.
    function automatic bit gather(input logic [7:0] b, input int unsigned len,
                                  output logic [63:0] v);
        int unsigned pos;
        pos = pp_idx & 7;
        pp_acc = pp_acc | (64'(b) << (8 * pos));
        v = pp_acc;
        if (pos + 1 >= len) begin
            pp_acc = '0;
            pp_idx = 0;
            return 1'b1;
        end
        pp_idx = pos + 1;
        return 1'b0;
    endfunction

    function automatic mhp_pkg::t_phase msg_hdr_done();
        return (pp_err != mhp_pkg::ST_OK) ? mhp_pkg::PH_DISCARD : mhp_pkg::PH_XFLAGS;
    endfunction

    function automatic mhp_pkg::t_phase dest_next();
        if (pp_dsiz == mhp_pkg::DSIZ_NODE) return mhp_pkg::PH_DSTNODE;
        if (pp_dsiz == mhp_pkg::DSIZ_GROUP) return mhp_pkg::PH_DSTGROUP;
        return msg_hdr_done();
    endfunction

    function automatic mhp_pkg::t_phase proto_hdr_done();
        return (pp_err != mhp_pkg::ST_OK) ? mhp_pkg::PH_DISCARD : mhp_pkg::PH_PAYLOAD;
    endfunction

    function automatic mhp_pkg::t_phase after_vendor_next();
        return pp_ack ? mhp_pkg::PH_ACK : proto_hdr_done();
    endfunction

    // Works out the result beats caused by one accepted byte.
    function automatic void predict_byte(input logic [7:0] b, input logic fend);
        logic [63:0] v;
        logic [2:0]  code;
        if (pp_count != '1) pp_count = pp_count + 1'b1;
        case (pp_phase)
            mhp_pkg::PH_MF: begin
                add_beat(mhp_pkg::KIND_MSGFLAGS, 64'(b), mhp_pkg::ST_OK, 1'b0);
                pp_src  = (b & mhp_pkg::MF_SRC_MASK) != 0;
                pp_dsiz = 2'(b & mhp_pkg::MF_DEST_BITS);
                if (pp_dsiz == mhp_pkg::DSIZ_RSVD) begin
                    pp_err   = mhp_pkg::ST_DEST_RSVD;
                    pp_phase = mhp_pkg::PH_DISCARD;
                end else begin
                    pp_phase = mhp_pkg::PH_SESSION;
                end
            end
            mhp_pkg::PH_SESSION: begin
                if (gather(b, 2, v)) begin
                    add_beat(mhp_pkg::KIND_SESSION, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = mhp_pkg::PH_SECF;
                end
            end
            mhp_pkg::PH_SECF: begin
                add_beat(mhp_pkg::KIND_SECFLAGS, 64'(b), mhp_pkg::ST_OK, 1'b0);
                if ((b & mhp_pkg::SF_MSGEXT_MASK) != 0) pp_err = mhp_pkg::ST_MSG_EXT;
                pp_phase = mhp_pkg::PH_COUNTER;
            end
            mhp_pkg::PH_COUNTER: begin
                if (gather(b, 4, v)) begin
                    add_beat(mhp_pkg::KIND_COUNTER, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = pp_src ? mhp_pkg::PH_SRC : dest_next();
                end
            end
            mhp_pkg::PH_SRC: begin
                if (gather(b, 8, v)) begin
                    add_beat(mhp_pkg::KIND_SRC, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = dest_next();
                end
            end
            mhp_pkg::PH_DSTNODE: begin
                if (gather(b, 8, v)) begin
                    add_beat(mhp_pkg::KIND_DSTNODE, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = msg_hdr_done();
                end
            end
            mhp_pkg::PH_DSTGROUP: begin
                if (gather(b, 2, v)) begin
                    add_beat(mhp_pkg::KIND_DSTGROUP, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = msg_hdr_done();
                end
            end
            mhp_pkg::PH_XFLAGS: begin
                add_beat(mhp_pkg::KIND_XFLAGS, 64'(b), mhp_pkg::ST_OK, 1'b0);
                pp_vendor = (b & mhp_pkg::XF_VENDOR_MASK) != 0;
                pp_ack    = (b & mhp_pkg::XF_ACK_MASK) != 0;
                if ((b & mhp_pkg::XF_SECEXT_MASK) != 0) pp_err = mhp_pkg::ST_SEC_EXT;
                pp_phase = mhp_pkg::PH_OPCODE;
            end
            mhp_pkg::PH_OPCODE: begin
                add_beat(mhp_pkg::KIND_OPCODE, 64'(b), mhp_pkg::ST_OK, 1'b0);
                pp_phase = mhp_pkg::PH_EXCH;
            end
            mhp_pkg::PH_EXCH: begin
                if (gather(b, 2, v)) begin
                    add_beat(mhp_pkg::KIND_EXCH, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = mhp_pkg::PH_PROTO;
                end
            end
            mhp_pkg::PH_PROTO: begin
                if (gather(b, 2, v)) begin
                    add_beat(mhp_pkg::KIND_PROTO, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = pp_vendor ? mhp_pkg::PH_VENDOR : after_vendor_next();
                end
            end
            mhp_pkg::PH_VENDOR: begin
                if (gather(b, 2, v)) begin
                    add_beat(mhp_pkg::KIND_VENDOR, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = after_vendor_next();
                end
            end
            mhp_pkg::PH_ACK: begin
                if (gather(b, 4, v)) begin
                    add_beat(mhp_pkg::KIND_ACKCTR, v, mhp_pkg::ST_OK, 1'b0);
                    pp_phase = proto_hdr_done();
                end
            end
            mhp_pkg::PH_PAYLOAD: begin
                add_beat(mhp_pkg::KIND_PAYLOAD, 64'(b), mhp_pkg::ST_OK, 1'b0);
            end
            default: begin
            end
        endcase
        // The frame-end byte closes the frame with a status beat.
        if (fend) begin
            if (pp_phase == mhp_pkg::PH_PAYLOAD) code = mhp_pkg::ST_OK;
            else if (pp_err != mhp_pkg::ST_OK) code = pp_err;
            else code = mhp_pkg::ST_TRUNCATED;
            add_beat(mhp_pkg::KIND_STATUS, 64'(pp_count), code, 1'b1);
            clear_walk();
        end
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns: %s", $time, what);
    endtask

    // Offers one byte, with a random gap first, and waits for its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic fend);
        @(negedge i_clk);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= fend;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(b, fend);
    endtask

    // Builds one random frame: mostly well-formed headers with random content,
    // some cut short, some pure noise.
    task automatic send_random_frame();
        logic [7:0] fr [$];
        logic [7:0] mf;
        logic [7:0] sf;
        logic [7:0] xf;
        int         roll;
        int         n;
        roll = $urandom_range(99);
        if (roll < 8) begin
            n = $urandom_range(24, 1);
            repeat (n) fr.push_back(8'($urandom));
        end else begin
            mf = 8'($urandom);
            mf[1:0] = ($urandom_range(99) < 5) ? mhp_pkg::DSIZ_RSVD : 2'($urandom_range(2));
            fr.push_back(mf);
            repeat (2) fr.push_back(8'($urandom));
            sf = 8'($urandom);
            if ($urandom_range(99) >= 10) sf = sf & ~mhp_pkg::SF_MSGEXT_MASK;
            fr.push_back(sf);
            repeat (4) fr.push_back(8'($urandom));
            if ((mf & mhp_pkg::MF_SRC_MASK) != 0) repeat (8) fr.push_back(8'($urandom));
            if (mf[1:0] == mhp_pkg::DSIZ_NODE) repeat (8) fr.push_back(8'($urandom));
            if (mf[1:0] == mhp_pkg::DSIZ_GROUP) repeat (2) fr.push_back(8'($urandom));
            xf = 8'($urandom);
            if ($urandom_range(99) >= 10) xf = xf & ~mhp_pkg::XF_SECEXT_MASK;
            fr.push_back(xf);
            repeat (5) fr.push_back(8'($urandom));
            if ((xf & mhp_pkg::XF_VENDOR_MASK) != 0) repeat (2) fr.push_back(8'($urandom));
            if ((xf & mhp_pkg::XF_ACK_MASK) != 0) repeat (4) fr.push_back(8'($urandom));
            repeat ($urandom_range(6)) fr.push_back(8'($urandom));
            if (roll < 23) begin
                n = $urandom_range(fr.size() - 1, 1);
                while (fr.size() > n) void'(fr.pop_back());
            end
        end
        foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
        rand_items += fr.size();
    endtask

    // Stops offering and waits until every expected beat has arrived.
    task automatic drain_beats();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (field_beats.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, and one long hold-off when armed.
    always @(negedge i_clk) begin
        if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Result checker: each accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        mhp_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (field_beats.size() == 0) begin
                log_failure($sformatf("unexpected beat: kind %0d value %h code %0d last %0d",
                                      o_field_kind, o_field_value, o_status_code, o_last));
            end else begin
                want = field_beats.pop_front();
                if (o_field_kind !== want.kind || o_field_value !== want.value ||
                    o_status_code !== want.code || o_last !== want.last) begin
                    log_failure($sformatf({"beat mismatch: expected kind %0d value %h ",
                                           "code %0d last %0d, got kind %0d value %h ",
                                           "code %0d last %0d"},
                                          want.kind, want.value, want.code, want.last,
                                          o_field_kind, o_field_value, o_status_code,
                                          o_last));
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_frame_end = 1'b0;
        clear_walk();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under light idling on both sides.
        send_pct = 19;
        recv_pct = 19;
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].fend);
            if (dir_rows[i].typed) field_beats[field_beats.size() - 1] = dir_rows[i].beat;
        end
        drain_beats();

        // Random frames over four idling phases; each phase ends with the
        // sender paused until all beats are back.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 48; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 48; end
                default: begin send_pct = 19; recv_pct = 19; end
            endcase
            if (ph == 0) hold_armed = 1'b1;
            while (rand_items < RAND_ITEMS * (ph + 1) / 4) send_random_frame();
            drain_beats();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
